### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the bypass relay sequencer.
// No dependencies; simulation builds get the checks, SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, switched off while reset is held.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked check that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

### hw/rtl/brs_pkg.sv
// Shared types and constants for the bypass relay sequencer.
// No dependencies.
package brs_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CNT_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTARY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_REL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ON    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_TICKS = 3'd5;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CNT_W-1:0] MUTE_RST     = 16'd10;
  localparam logic [CNT_W-1:0] RELAY_RST    = 16'd10;

  typedef enum logic [9:0] {
    PH_START    = 10'b00_0000_0001,
    PH_IDLE     = 10'b00_0000_0010,
    PH_SM_MUTE  = 10'b00_0000_0100,
    PH_SM_RELAY = 10'b00_0000_1000,
    PH_M_MUTE   = 10'b00_0001_0000,
    PH_M_RELAY  = 10'b00_0010_0000,
    PH_T_MUTE   = 10'b00_0100_0000,
    PH_T_R2     = 10'b00_1000_0000,
    PH_T_R1     = 10'b01_0000_0000,
    PH_REL      = 10'b10_0000_0000
  } phase_t;

  // Debounce status for one switch.
  typedef struct packed {
    logic             differ;   // raw level differs from accepted level
    logic             ready;    // new level has held long enough
    logic [CNT_W-1:0] cnt_inc;  // saturating incremented hold count
  } deb_t;

endpackage

### hw/rtl/bypass_relay_sequencer.sv
// Top level of the bypass relay sequencer.
// Depends on brs_pkg, brs_debounce and assert_macros.svh.

// One input transaction is one switch sample tick; every accepted transaction
// yields exactly one result transaction holding the drive levels after that
// tick. The sample goes into an input register, one pass of short logic
// (two debounce compares, the timer decrement and the phase sequencer)
// updates the state and fills the result register. A new sample is taken in
// every cycle while the result register is empty or being drained, so the
// sustained rate is one transaction per clock while out_tready stays high.
// Timed waits (mute_ticks, relay_ticks, the startup debounce_ticks) count
// ticks, that is, accepted samples, not clocks.
// Configuration writes are taken in any cycle (cfg_ready is tied high) and
// are meant to happen while the block is idle.
module bypass_relay_sequencer import brs_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] foot_pressed, [1] mode_thrown, [7:2] zero
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] relay_one, [1] relay_two, [2] mute_on,
                                            // [3] led_on, [4] effect_active,
                                            // [5] trail_active, [6] busy_res, [7] zero
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  // width used to compare the startup timer with debounce_ticks
  localparam int CW = (TIMER_WIDTH > CNT_W) ? TIMER_WIDTH : CNT_W;

  // configuration registers
  logic             momentary_r, toggle_rel_r, start_on_r;
  logic [CNT_W-1:0] debounce_r, mute_ticks_r, relay_ticks_r;

  // input stage
  logic in_valid_r, foot_in_r, mode_in_r;
  logic advance;

  // sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] wait_r, wait_nxt;
  logic [CNT_W-1:0]       foot_cnt_r, foot_cnt_nxt;
  logic [CNT_W-1:0]       mode_cnt_r, mode_cnt_nxt;
  logic                   foot_acc_r, foot_acc_nxt;
  logic                   effect_r, effect_nxt;
  logic                   trail_r, trail_nxt;
  logic                   relay1_r, relay1_nxt;
  logic                   relay2_r, relay2_nxt;
  logic                   mute_r, mute_nxt;
  logic                   led_r, led_nxt;
  logic                   second_due_r, second_due_nxt;

  // result register
  logic       out_valid_r;
  logic [6:0] out_data_r;

  deb_t foot_deb, mode_deb;
  logic press, mode_ready;
  logic [TIMER_WIDTH-1:0] mute_load, relay_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      momentary_r    <= 1'b0;
      toggle_rel_r   <= 1'b0;
      start_on_r     <= 1'b0;
      debounce_r     <= DEBOUNCE_RST;
      mute_ticks_r   <= MUTE_RST;
      relay_ticks_r  <= RELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MOMENTARY:   momentary_r   <= cfg_data[0];
        CFG_TOGGLE_REL:  toggle_rel_r  <= cfg_data[0];
        CFG_START_ON:    start_on_r    <= cfg_data[0];
        CFG_DEBOUNCE:    debounce_r    <= cfg_data;
        CFG_MUTE_TICKS:  mute_ticks_r  <= cfg_data;
        CFG_RELAY_TICKS: relay_ticks_r <= cfg_data;
        default: ;  // writes beyond the register list are ignored
      endcase
    end
  end

  // Handshake: the tick in the input register moves on when the result
  // register is empty or its transaction is taken this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      foot_in_r <= in_tdata[0];
      mode_in_r <= in_tdata[1];
    end
  end

  brs_debounce u_foot_deb (
    .level    (foot_in_r),
    .accepted (foot_acc_r),
    .cnt      (foot_cnt_r),
    .limit    (debounce_r),
    .status   (foot_deb)
  );

  // the mode switch is compared with the mode in force
  brs_debounce u_mode_deb (
    .level    (mode_in_r),
    .accepted (trail_r),
    .cnt      (mode_cnt_r),
    .limit    (debounce_r),
    .status   (mode_deb)
  );

  assign mute_load  = TIMER_WIDTH'(mute_ticks_r);
  assign relay_load = TIMER_WIDTH'(relay_ticks_r);

  // One tick of the sequencer.
  always_comb begin
    phase_nxt      = phase_r;
    wait_nxt       = wait_r;
    foot_cnt_nxt   = foot_cnt_r;
    mode_cnt_nxt   = mode_cnt_r;
    foot_acc_nxt   = foot_acc_r;
    effect_nxt     = effect_r;
    trail_nxt      = trail_r;
    relay1_nxt     = relay1_r;
    relay2_nxt     = relay2_r;
    mute_nxt       = mute_r;
    led_nxt        = led_r;
    second_due_nxt = second_due_r;
    press          = 1'b0;

    // foot debounce: an accepted new level resets the hold count
    if (foot_deb.differ) begin
      if (foot_deb.ready) begin
        foot_acc_nxt = foot_in_r;
        foot_cnt_nxt = '0;
        press        = foot_in_r;
      end else begin
        foot_cnt_nxt = foot_deb.cnt_inc;
      end
    end else begin
      foot_cnt_nxt = '0;
    end

    // mode debounce: count is cleared when the level matches again or once the change is acted on
    mode_cnt_nxt = mode_deb.differ ? mode_deb.cnt_inc : '0;
    mode_ready   = mode_deb.ready;

    unique case (phase_r)
      PH_START: begin
        if (CW'(wait_r) >= CW'(debounce_r)) begin
          wait_nxt = '0;
          if (mode_in_r && !trail_r) begin
            mute_nxt  = 1'b1;
            wait_nxt  = mute_load;
            phase_nxt = PH_SM_MUTE;
          end else if (start_on_r) begin
            mute_nxt       = 1'b1;
            wait_nxt       = mute_load;
            second_due_nxt = 1'b0;
            phase_nxt      = PH_T_MUTE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          wait_nxt = wait_r + TIMER_WIDTH'(1);
        end
      end
      PH_SM_MUTE, PH_M_MUTE: begin
        if (wait_r == '0) begin
          relay1_nxt = !trail_r;
          wait_nxt   = relay_load;
          phase_nxt  = (phase_r == PH_SM_MUTE) ? PH_SM_RELAY : PH_M_RELAY;
        end else begin
          wait_nxt = wait_r - TIMER_WIDTH'(1);
        end
      end
      PH_SM_RELAY: begin
        if (wait_r == '0) begin
          mute_nxt     = 1'b0;
          trail_nxt    = !trail_r;
          mode_cnt_nxt = '0;
          if (start_on_r) begin
            mute_nxt       = 1'b1;
            wait_nxt       = mute_load;
            second_due_nxt = 1'b0;
            phase_nxt      = PH_T_MUTE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          wait_nxt = wait_r - TIMER_WIDTH'(1);
        end
      end
      PH_M_RELAY: begin
        if (wait_r == '0) begin
          mute_nxt     = 1'b0;
          trail_nxt    = !trail_r;
          mode_cnt_nxt = '0;
          phase_nxt    = PH_IDLE;
        end else begin
          wait_nxt = wait_r - TIMER_WIDTH'(1);
        end
      end
      PH_T_MUTE: begin
        if (wait_r == '0) begin
          relay2_nxt = !relay2_r;
          wait_nxt   = relay_load;
          phase_nxt  = PH_T_R2;
        end else begin
          wait_nxt = wait_r - TIMER_WIDTH'(1);
        end
      end
      PH_T_R2, PH_T_R1: begin
        if (wait_r == '0) begin
          if (phase_r == PH_T_R2 && !trail_r) begin
            // normal mode: relay one follows relay two
            relay1_nxt = !relay1_r;
            wait_nxt   = relay_load;
            phase_nxt  = PH_T_R1;
          end else begin
            mute_nxt       = 1'b0;
            led_nxt        = !led_r;
            effect_nxt     = !effect_r;
            phase_nxt      = second_due_r ? PH_REL : PH_IDLE;
            second_due_nxt = 1'b0;
          end
        end else begin
          wait_nxt = wait_r - TIMER_WIDTH'(1);
        end
      end
      PH_REL: begin
        // waits for the debounced release, including one accepted this tick
        if (!foot_acc_nxt) begin
          mute_nxt       = 1'b1;
          wait_nxt       = mute_load;
          second_due_nxt = 1'b0;
          phase_nxt      = PH_T_MUTE;
        end
      end
      default: begin
        // idle, and any code that is not a phase
        phase_nxt = PH_IDLE;
        if (press) begin
          if (momentary_r) begin
            mute_nxt       = 1'b1;
            wait_nxt       = mute_load;
            second_due_nxt = 1'b1;
            phase_nxt      = PH_T_MUTE;
          end else if (toggle_rel_r) begin
            second_due_nxt = 1'b0;
            phase_nxt      = PH_REL;
          end else begin
            mute_nxt       = 1'b1;
            wait_nxt       = mute_load;
            second_due_nxt = 1'b0;
            phase_nxt      = PH_T_MUTE;
          end
        end else if (mode_ready) begin
          mode_cnt_nxt = '0;
          if (effect_r) begin
            trail_nxt = mode_in_r;
          end else begin
            mute_nxt  = 1'b1;
            wait_nxt  = mute_load;
            phase_nxt = PH_M_MUTE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      wait_r       <= '0;
      foot_cnt_r   <= '0;
      mode_cnt_r   <= '0;
      foot_acc_r   <= 1'b0;
      effect_r     <= 1'b0;
      trail_r      <= 1'b0;
      relay1_r     <= 1'b0;
      relay2_r     <= 1'b0;
      mute_r       <= 1'b0;
      led_r        <= 1'b0;
      second_due_r <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      wait_r       <= wait_nxt;
      foot_cnt_r   <= foot_cnt_nxt;
      mode_cnt_r   <= mode_cnt_nxt;
      foot_acc_r   <= foot_acc_nxt;
      effect_r     <= effect_nxt;
      trail_r      <= trail_nxt;
      relay1_r     <= relay1_nxt;
      relay2_r     <= relay2_nxt;
      mute_r       <= mute_nxt;
      led_r        <= led_nxt;
      second_due_r <= second_due_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {phase_nxt != PH_IDLE, trail_nxt, effect_nxt, led_nxt,
                     mute_nxt, relay2_nxt, relay1_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  // checks
  `ASSERT_RST(a_phase_onehot, clk, rst_n, $onehot(phase_r))
  `ASSERT_RST(a_idle_unmuted, clk, rst_n, (phase_r == PH_IDLE) |-> !mute_r)
  `ASSERT_RST(a_led_tracks_effect, clk, rst_n, led_r == effect_r)
  `ASSERT_RST(a_take_when_drained, clk, rst_n, !out_valid_r |-> in_tready)

endmodule

### hw/rtl/brs_debounce.sv
// Debounce compare for one switch: saturating hold count and acceptance test.
// Depends on brs_pkg.
module brs_debounce import brs_pkg::*; (
  input  logic             level,
  input  logic             accepted,
  input  logic [CNT_W-1:0] cnt,
  input  logic [CNT_W-1:0] limit,
  output deb_t             status
);

  logic [CNT_W-1:0] inc;

  assign inc = (cnt == {CNT_W{1'b1}}) ? cnt : cnt + CNT_W'(1);

  assign status.differ  = level ^ accepted;
  assign status.ready   = (level ^ accepted) && (inc >= limit);
  assign status.cnt_inc = inc;

endmodule
